// ----- hw/rtl/ncbts_pkg.sv -----
// shared types and constants for the nested comment and brace text scanner
// character codes, token kinds and stream widths; no dependencies
package ncbts_pkg;

    localparam int CHAR_W       = 21;
    localparam int MASK_W       = 4;
    localparam int OUT_LEN_W    = 16;
    localparam int KIND_W       = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 3;

    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [MASK_W-1:0]    t_mask;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [OUT_LEN_W-1:0] t_out_len;

    localparam t_char CH_EOI    = 21'h00000;
    localparam t_char CH_TAB    = 21'h00009;
    localparam t_char CH_SPACE  = 21'h00020;
    localparam t_char CH_DQUOTE = 21'h00022;
    localparam t_char CH_SQUOTE = 21'h00027;
    localparam t_char CH_STAR   = 21'h0002A;
    localparam t_char CH_SLASH  = 21'h0002F;
    localparam t_char CH_BSLASH = 21'h0005C;
    localparam t_char CH_LBRACE = 21'h0007B;
    localparam t_char CH_RBRACE = 21'h0007D;

    localparam t_kind KIND_END     = 2'd0;
    localparam t_kind KIND_COMMENT = 2'd1;
    localparam t_kind KIND_TERM    = 2'd2;
    localparam t_kind KIND_MATH    = 2'd3;

    localparam int MASK_END_BIT  = 0;
    localparam int MASK_TERM_BIT = 2;
    localparam int MASK_MATH_BIT = 3;

endpackage

// ----- hw/rtl/nested_comment_and_brace_text_scanner_top.sv -----
// Scans a character stream for one token per scan: end of input, a nested slash-star
// comment, a closing-brace terminator or brace-balanced math text. One character is
// taken per clock cycle; the scan state updates in the same cycle and a result, when
// the character ends a scan, sits in the output register from the next cycle on. The
// input keeps taking characters while that result waits, unless the output register
// is full and not being drained, so the rate is one character per cycle. A transaction
// with tuser set starts a new scan and drops any unfinished one. Depths and counts
// saturate at 2^COUNT_WIDTH-1; reported lengths saturate at 65535.
// top level of the scanner; depends on ncbts_pkg
module nested_comment_and_brace_text_scanner_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // character [20:0], valid_mask [24:21], zero [31:25]
    input  logic [ncbts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // first_of_scan [0]
    input  logic [ncbts_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // token_length [15:0], skipped_count [31:16]
    output logic [ncbts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // accepted [0], token_kind [2:1]
    output logic [ncbts_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    import ncbts_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int WW = (CW > OUT_LEN_W) ? CW : OUT_LEN_W;

    typedef logic [CW-1:0] t_count;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_MATH,
        PH_COPEN,
        PH_CBODY
    } t_phase;

    function automatic t_count sat_inc(input t_count v);
        t_count res;
        res = (v == '1) ? v : v + t_count'(1);
        return res;
    endfunction

    function automatic t_out_len clamp_out(input t_count v);
        logic [WW-1:0] ext;
        t_out_len      res;
        ext = WW'(v);
        res = (ext > WW'(17'h0FFFF)) ? '1 : t_out_len'(ext);
        return res;
    endfunction

    t_phase   r_phase, n_phase;
    t_mask    r_allowed, n_allowed;
    t_count   r_cdepth, n_cdepth;
    t_count   r_bdepth, n_bdepth;
    logic     r_in_quote, n_in_quote;
    logic     r_quote_single, n_quote_single;
    logic     r_escape, n_escape;
    logic     r_star, n_star;
    logic     r_slash, n_slash;
    t_count   r_len, n_len;
    t_count   r_skip, n_skip;

    logic     r_out_valid;
    logic     r_out_acc;
    t_kind    r_out_kind;
    t_out_len r_out_len;
    t_out_len r_out_skip;

    t_char    in_char;
    t_mask    in_mask;
    logic     in_first;
    logic     in_fire;

    logic     emit;
    logic     res_acc;
    t_kind    res_kind;
    t_count   res_len;

    assign in_char  = s_axis_tdata[CHAR_W-1:0];
    assign in_mask  = s_axis_tdata[CHAR_W+MASK_W-1:CHAR_W];
    assign in_first = s_axis_tuser[0];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        t_phase b_phase;
        t_count b_cdepth;
        t_count b_bdepth;
        logic   b_in_quote;
        logic   b_quote_single;
        logic   b_escape;
        logic   b_star;
        logic   b_slash;
        t_count b_len;
        t_count b_skip;
        logic   do_term;
        logic   do_math;
        logic   do_last;
        logic   ended;
        logic   single;
        t_count dec;

        if (in_first) begin
            b_phase        = PH_IDLE;
            n_allowed      = in_mask;
            b_cdepth       = '0;
            b_bdepth       = '0;
            b_in_quote     = 1'b0;
            b_quote_single = 1'b0;
            b_escape       = 1'b0;
            b_star         = 1'b0;
            b_slash        = 1'b0;
            b_len          = '0;
            b_skip         = '0;
        end else begin
            b_phase        = r_phase;
            n_allowed      = r_allowed;
            b_cdepth       = r_cdepth;
            b_bdepth       = r_bdepth;
            b_in_quote     = r_in_quote;
            b_quote_single = r_quote_single;
            b_escape       = r_escape;
            b_star         = r_star;
            b_slash        = r_slash;
            b_len          = r_len;
            b_skip         = r_skip;
        end

        n_phase        = b_phase;
        n_cdepth       = b_cdepth;
        n_bdepth       = b_bdepth;
        n_in_quote     = b_in_quote;
        n_quote_single = b_quote_single;
        n_escape       = b_escape;
        n_star         = b_star;
        n_slash        = b_slash;
        n_len          = b_len;
        n_skip         = b_skip;

        emit     = 1'b0;
        res_acc  = 1'b0;
        res_kind = KIND_END;
        res_len  = '0;
        do_term  = in_first || (r_phase == PH_SKIP);
        do_math  = 1'b0;
        do_last  = 1'b0;
        ended    = 1'b0;
        single   = 1'b0;
        dec      = '0;

        // terminator stage, skip of blanks and math entry; otherwise the math and comment phases
        if (do_term) begin
            if (n_allowed[MASK_TERM_BIT] && (in_char == CH_SPACE || in_char == CH_TAB)) begin
                n_skip  = sat_inc(b_skip);
                n_phase = PH_SKIP;
            end else if (n_allowed[MASK_TERM_BIT] && in_char == CH_RBRACE) begin
                emit     = 1'b1;
                res_acc  = 1'b1;
                res_kind = KIND_TERM;
            end else if (n_allowed[MASK_MATH_BIT] && in_char != CH_RBRACE
                         && in_char != CH_EOI) begin
                n_phase = PH_MATH;
                do_math = 1'b1;
            end else begin
                do_last = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_MATH: begin
                    do_math = 1'b1;
                end
                PH_COPEN: begin
                    if (in_char != CH_STAR) begin
                        emit = 1'b1;
                    end else begin
                        n_len    = sat_inc(b_len);
                        n_cdepth = t_count'(1);
                        n_star   = 1'b0;
                        n_slash  = 1'b0;
                        n_phase  = PH_CBODY;
                    end
                end
                PH_CBODY: begin
                    n_slash = 1'b0;
                    if (b_slash && in_char == CH_STAR) begin
                        n_cdepth = sat_inc(b_cdepth);
                        n_len    = sat_inc(b_len);
                    end else if (in_char == CH_EOI) begin
                        emit = 1'b1;
                    end else begin
                        n_len = sat_inc(b_len);
                        if (in_char == CH_STAR) begin
                            n_star = 1'b1;
                        end else if (in_char == CH_SLASH) begin
                            if (b_star) begin
                                n_star   = 1'b0;
                                dec      = (b_cdepth != '0) ? b_cdepth - t_count'(1) : '0;
                                n_cdepth = dec;
                                if (dec == '0) begin
                                    emit     = 1'b1;
                                    res_acc  = 1'b1;
                                    res_kind = KIND_COMMENT;
                                    res_len  = n_len;
                                end
                            end else begin
                                n_slash = 1'b1;
                            end
                        end else begin
                            n_star = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // one character of math text
        if (do_math) begin
            n_escape = 1'b0;
            if (b_escape && in_char != CH_EOI) begin
                n_len = sat_inc(b_len);
            end else if (in_char == CH_EOI) begin
                emit     = 1'b1;
                res_acc  = 1'b1;
                res_kind = KIND_MATH;
                res_len  = b_len;
            end else begin
                if (in_char == CH_BSLASH) begin
                    n_escape = 1'b1;
                end else if (in_char == CH_DQUOTE || in_char == CH_SQUOTE) begin
                    single = (in_char == CH_SQUOTE);
                    if (b_in_quote && single == b_quote_single) begin
                        n_in_quote     = 1'b0;
                        n_quote_single = 1'b0;
                    end else if (!b_in_quote) begin
                        n_in_quote     = 1'b1;
                        n_quote_single = single;
                    end
                end else if (in_char == CH_LBRACE) begin
                    if (!b_in_quote) begin
                        n_bdepth = sat_inc(b_bdepth);
                    end
                end else if (in_char == CH_RBRACE && !b_in_quote) begin
                    if (b_bdepth == '0) begin
                        ended    = 1'b1;
                        emit     = 1'b1;
                        res_acc  = 1'b1;
                        res_kind = KIND_MATH;
                        res_len  = b_len;
                    end else begin
                        n_bdepth = b_bdepth - t_count'(1);
                    end
                end
                if (!ended) begin
                    n_len = sat_inc(b_len);
                end
            end
        end

        // end token, comment opener or rejection
        if (do_last) begin
            if (n_allowed[MASK_END_BIT] && in_char == CH_EOI) begin
                emit     = 1'b1;
                res_acc  = 1'b1;
                res_kind = KIND_END;
            end else if (in_char == CH_SLASH) begin
                n_len   = sat_inc(b_len);
                n_phase = PH_COPEN;
            end else begin
                emit = 1'b1;
            end
        end

        if (emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_allowed      <= '0;
            r_cdepth       <= '0;
            r_bdepth       <= '0;
            r_in_quote     <= 1'b0;
            r_quote_single <= 1'b0;
            r_escape       <= 1'b0;
            r_star         <= 1'b0;
            r_slash        <= 1'b0;
            r_len          <= '0;
            r_skip         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase        <= n_phase;
                r_allowed      <= n_allowed;
                r_cdepth       <= n_cdepth;
                r_bdepth       <= n_bdepth;
                r_in_quote     <= n_in_quote;
                r_quote_single <= n_quote_single;
                r_escape       <= n_escape;
                r_star         <= n_star;
                r_slash        <= n_slash;
                r_len          <= n_len;
                r_skip         <= n_skip;
            end
            if (in_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire && emit) begin
            r_out_acc  <= res_acc;
            r_out_kind <= res_kind;
            r_out_len  <= clamp_out(res_len);
            r_out_skip <= clamp_out(n_skip);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_skip, r_out_len};
    assign m_axis_tuser  = {r_out_kind, r_out_acc};

endmodule

// ----- sim/nested_comment_and_brace_text_scanner_top_tb.sv -----
// self-checking testbench for the nested comment and brace text scanner top level
// a scoreboard class predicts one token per scan; tasks drive and drain both streams
// depends on ncbts_pkg and nested_comment_and_brace_text_scanner_top
module nested_comment_and_brace_text_scanner_top_tb;
    import ncbts_pkg::*;

    localparam int CNT_W        = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 400;

    localparam t_char CH_LETTER_A = 21'h00061;
    localparam t_char CH_PLAIN    = 21'h00078;
    localparam t_char CH_TOP      = 21'h1FFFFF;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_MATH,
        ST_OPEN,
        ST_BODY
    } t_scan_state;

    typedef struct packed {
        logic     ok;
        t_kind    kind;
        t_out_len length;
        t_out_len skipped;
    } t_token;

    class token_scoreboard;
        t_token      expected[$];
        int unsigned error_count;
        t_scan_state state;
        t_mask       allow_mask;
        t_cnt        nest_level;
        t_cnt        brace_level;
        bit          quote_open;
        bit          string_single;
        bit          escaped;
        bit          star_pending;
        bit          after_slash;
        t_cnt        token_len;
        t_cnt        skip_len;

        function new();
            error_count = 0;
            clear();
        endfunction

        function void clear();
            state         = ST_IDLE;
            allow_mask    = '0;
            nest_level    = '0;
            brace_level   = '0;
            quote_open    = 1'b0;
            string_single = 1'b0;
            escaped       = 1'b0;
            star_pending  = 1'b0;
            after_slash   = 1'b0;
            token_len     = '0;
            skip_len      = '0;
        endfunction

        function t_cnt sat_inc(t_cnt v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function t_out_len clip_len(t_cnt v);
            return (v > t_cnt'({OUT_LEN_W{1'b1}})) ? '1 : t_out_len'(v);
        endfunction

        function bit close_scan(logic ok, t_kind kind, t_cnt len, output t_token t);
            t.ok      = ok;
            t.kind    = kind;
            t.length  = clip_len(len);
            t.skipped = clip_len(skip_len);
            state     = ST_IDLE;
            return 1'b1;
        endfunction

        function bit body_step(t_char c, output t_token t);
            if (after_slash) begin
                after_slash = 1'b0;
                if (c == CH_STAR) begin
                    nest_level = sat_inc(nest_level);
                    token_len  = sat_inc(token_len);
                    return 1'b0;
                end
            end
            if (c == CH_EOI) return close_scan(1'b0, KIND_END, '0, t);
            token_len = sat_inc(token_len);
            if (c == CH_STAR) begin
                star_pending = 1'b1;
            end else if (c == CH_SLASH) begin
                if (star_pending) begin
                    star_pending = 1'b0;
                    if (nest_level != 0) nest_level = nest_level - 1'b1;
                    if (nest_level == 0) return close_scan(1'b1, KIND_COMMENT, token_len, t);
                end else begin
                    after_slash = 1'b1;
                end
            end else begin
                star_pending = 1'b0;
            end
            return 1'b0;
        endfunction

        function bit open_step(t_char c, output t_token t);
            if (c != CH_STAR) return close_scan(1'b0, KIND_END, '0, t);
            token_len    = sat_inc(token_len);
            nest_level   = 1;
            star_pending = 1'b0;
            after_slash  = 1'b0;
            state        = ST_BODY;
            return 1'b0;
        endfunction

        function bit end_or_comment(t_char c, output t_token t);
            if (allow_mask[MASK_END_BIT] && c == CH_EOI) return close_scan(1'b1, KIND_END, '0, t);
            if (c == CH_SLASH) begin
                token_len = sat_inc(token_len);
                state     = ST_OPEN;
                return 1'b0;
            end
            return close_scan(1'b0, KIND_END, '0, t);
        endfunction

        function bit math_step(t_char c, output t_token t);
            bit single;
            if (escaped) begin
                escaped = 1'b0;
                if (c != CH_EOI) begin
                    token_len = sat_inc(token_len);
                    return 1'b0;
                end
            end
            if (c == CH_EOI) return close_scan(1'b1, KIND_MATH, token_len, t);
            if (c == CH_BSLASH) begin
                escaped = 1'b1;
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                single = (c == CH_SQUOTE);
                if (quote_open && single == string_single) begin
                    quote_open    = 1'b0;
                    string_single = 1'b0;
                end else if (!quote_open) begin
                    quote_open    = 1'b1;
                    string_single = single;
                end
            end else if (c == CH_LBRACE) begin
                if (!quote_open) brace_level = sat_inc(brace_level);
            end else if (c == CH_RBRACE && !quote_open) begin
                if (brace_level == 0) return close_scan(1'b1, KIND_MATH, token_len, t);
                brace_level = brace_level - 1'b1;
            end
            token_len = sat_inc(token_len);
            return 1'b0;
        endfunction

        function bit try_math(t_char c, output t_token t);
            if (allow_mask[MASK_MATH_BIT] && c != CH_RBRACE && c != CH_EOI) begin
                state = ST_MATH;
                return math_step(c, t);
            end
            return end_or_comment(c, t);
        endfunction

        function bit after_blanks(t_char c, output t_token t);
            if (allow_mask[MASK_TERM_BIT]) begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    skip_len = sat_inc(skip_len);
                    state    = ST_SKIP;
                    return 1'b0;
                end
                if (c == CH_RBRACE) return close_scan(1'b1, KIND_TERM, '0, t);
            end
            return try_math(c, t);
        endfunction

        // returns 1 when the character reached a scan rather than being ignored
        function bit note_character(t_char c, bit first, t_mask mask);
            t_token t;
            bit     got;
            bit     live;
            live = first || (state != ST_IDLE);
            got  = 1'b0;
            if (first) begin
                clear();
                allow_mask = mask;
                got = after_blanks(c, t);
            end else begin
                case (state)
                    ST_SKIP: got = after_blanks(c, t);
                    ST_MATH: got = math_step(c, t);
                    ST_OPEN: got = open_step(c, t);
                    ST_BODY: got = body_step(c, t);
                    default: got = 1'b0;
                endcase
            end
            if (got) expected.push_back(t);
            return live;
        endfunction

        function bit busy();
            return state != ST_IDLE;
        endfunction

        function int pending_count();
            return expected.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
            error_count++;
        endtask

        task check_token(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
            t_token want;
            if (expected.size() == 0) begin
                report("token with nothing expected", d, 0);
                return;
            end
            want = expected.pop_front();
            if (u[0] !== want.ok) report("accepted", u[0], want.ok);
            if (u[2:1] !== want.kind) report("token_kind", u[2:1], want.kind);
            if (d[OUT_LEN_W-1:0] !== want.length) begin
                report("token_length", d[OUT_LEN_W-1:0], want.length);
            end
            if (d[2*OUT_LEN_W-1:OUT_LEN_W] !== want.skipped) begin
                report("skipped_count", d[2*OUT_LEN_W-1:OUT_LEN_W], want.skipped);
            end
        endtask

        task check_leftovers();
            if (expected.size() != 0) report("tokens never delivered", expected.size(), 0);
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    token_scoreboard tokens;
    bit              no_idle;
    int unsigned     live_items;
    int unsigned     stall_cycles;
    t_mask           cur_mask;
    bit              start_flag;

    nested_comment_and_brace_text_scanner_top #(
        .COUNT_WIDTH(CNT_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5;
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic t_char pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic t_char pick_letter();
        return CH_LETTER_A + t_char'($urandom_range(0, 25));
    endfunction

    function automatic t_char pick_char();
        case ($urandom_range(0, 11))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_DQUOTE;
            3:       return CH_SQUOTE;
            4:       return CH_BSLASH;
            5:       return CH_SPACE;
            6:       return CH_TAB;
            7:       return t_char'($urandom_range(0, CH_TOP));
            8:       return CH_STAR;
            9:       return CH_SLASH;
            default: return pick_letter();
        endcase
    endfunction

    // results land on the other side; the receiver process checks them
    task automatic send_char(t_char c, bit first, t_mask mask);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({mask, c});
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (tokens.note_character(c, first, mask)) live_items++;
        @(negedge i_clk);
    endtask

    task automatic begin_scan(t_mask mask);
        cur_mask   = mask;
        start_flag = 1'b1;
    endtask

    task automatic put(t_char c);
        send_char(c, start_flag, start_flag ? cur_mask : t_mask'($urandom_range(0, 15)));
        start_flag = 1'b0;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (tokens.pending_count() != 0);
    endtask

    task automatic lead_blanks();
        if (cur_mask[MASK_TERM_BIT]) repeat ($urandom_range(0, 3)) put(pick_blank());
    endtask

    task automatic gen_terminator();
        begin_scan(t_mask'($urandom_range(0, 15)) | t_mask'(1 << MASK_TERM_BIT));
        lead_blanks();
        put(CH_RBRACE);
    endtask

    task automatic gen_end();
        begin_scan(t_mask'($urandom_range(0, 15)) | t_mask'(1 << MASK_END_BIT));
        lead_blanks();
        put(CH_EOI);
    endtask

    task automatic gen_math();
        t_char c;
        begin_scan(t_mask'($urandom_range(0, 15)) | t_mask'(1 << MASK_MATH_BIT));
        lead_blanks();
        do begin
            c = pick_char();
        end while (c == CH_RBRACE || c == CH_EOI ||
                   (cur_mask[MASK_TERM_BIT] && (c == CH_SPACE || c == CH_TAB)));
        put(c);
        repeat ($urandom_range(0, 12)) if (tokens.busy()) put(pick_char());
        while (tokens.busy()) put($urandom_range(0, 1) ? CH_RBRACE : CH_EOI);
    endtask

    task automatic gen_comment();
        begin_scan(t_mask'($urandom_range(0, 15)) & ~t_mask'(1 << MASK_MATH_BIT));
        lead_blanks();
        put(CH_SLASH);
        if ($urandom_range(0, 7) == 0) begin
            put(pick_letter());
            return;
        end
        put(CH_STAR);
        repeat ($urandom_range(0, 20)) begin
            if (tokens.busy()) begin
                case ($urandom_range(0, 4))
                    0: put(CH_STAR);
                    1: put(CH_SLASH);
                    2: begin
                        put(CH_SLASH);
                        if (tokens.busy()) put(CH_STAR);
                    end
                    3: begin
                        put(CH_STAR);
                        if (tokens.busy()) put(CH_SLASH);
                    end
                    default: put(pick_char());
                endcase
            end
        end
        if (tokens.busy()) begin
            if ($urandom_range(0, 5) == 0) begin
                put(CH_EOI);
            end else begin
                // a plain character clears a pending slash so the closers below count
                put(CH_PLAIN);
                while (tokens.busy()) begin
                    put(CH_STAR);
                    if (tokens.busy()) put(CH_SLASH);
                end
            end
        end
    endtask

    task automatic gen_restart();
        begin_scan(t_mask'(1 << MASK_MATH_BIT));
        put(pick_letter());
        put(pick_letter());
        case ($urandom_range(0, 2))
            0:       gen_terminator();
            1:       gen_comment();
            default: gen_math();
        endcase
    endtask

    task automatic gen_noise();
        send_char($urandom_range(0, 7) == 0 ? CH_EOI : pick_char(),
                  $urandom_range(0, 3) == 0, t_mask'($urandom_range(0, 15)));
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            repeat (pick_gap()) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            tokens.check_token(m_axis_tdata, m_axis_tuser);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned next_pause;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        stall_cycles  = 0;
        no_idle       = 1'b0;
        live_items    = 0;
        start_flag    = 1'b0;
        cur_mask      = '0;
        tokens        = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle character, skipped blanks ending in a terminator, then accepted and refused end of input
        send_char(CH_PLAIN, 1'b0, '1);
        begin_scan(4'hF);
        put(CH_SPACE);
        put(CH_TAB);
        put(CH_RBRACE);
        begin_scan(t_mask'(1 << MASK_END_BIT));
        put(CH_EOI);
        begin_scan('0);
        put(CH_EOI);
        // quoted brace, then escape right before end of input, then a quoted brace inside a braced group
        begin_scan(t_mask'(1 << MASK_MATH_BIT));
        put(CH_DQUOTE);
        put(CH_RBRACE);
        put(CH_DQUOTE);
        put(CH_BSLASH);
        put(CH_EOI);
        begin_scan(t_mask'(1 << MASK_MATH_BIT));
        put(CH_LBRACE);
        put(CH_SQUOTE);
        put(CH_RBRACE);
        put(CH_SQUOTE);
        put(CH_RBRACE);
        put(CH_RBRACE);
        // nested comment
        begin_scan(t_mask'(1 << MASK_END_BIT));
        put(CH_SLASH);
        put(CH_STAR);
        put(CH_SLASH);
        put(CH_STAR);
        put(CH_STAR);
        put(CH_SLASH);
        put(CH_STAR);
        put(CH_SLASH);
        // restart drops the open scan, then the top character code as math text
        begin_scan(t_mask'(1 << MASK_MATH_BIT));
        put(CH_PLAIN);
        begin_scan(t_mask'(1 << MASK_TERM_BIT));
        put(CH_RBRACE);
        begin_scan(t_mask'(1 << MASK_MATH_BIT));
        put(CH_TOP);
        put(CH_EOI);
        hold_until_drained();

        live_items = 0;
        next_pause = 100;
        while (live_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
            case ($urandom_range(0, 9))
                0:       gen_terminator();
                1:       gen_end();
                2, 3, 4: gen_math();
                5, 6, 7: gen_comment();
                8:       gen_restart();
                default: gen_noise();
            endcase
            if (live_items >= next_pause) begin
                hold_until_drained();
                next_pause = next_pause + 100;
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        tokens.check_leftovers();
        if (tokens.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
